FILE: rtl/ilc_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, codes and item types for the indexed list block.
// ----------------------------------------------------------------------------
package ilc_pkg;

   localparam int LIST_CAPACITY = 64;
   localparam int DATA_WIDTH    = 32;
   localparam int ADDR_WIDTH    = $clog2(LIST_CAPACITY);
   localparam int COUNT_WIDTH   = $clog2(LIST_CAPACITY + 1);

   localparam int OPCODE_WIDTH  = 2;
   localparam int POS_WIDTH     = 6;
   localparam int VALUE_WIDTH   = 32;
   localparam int ENTRY_WIDTH   = 7;
   localparam int ERROR_WIDTH   = 2;

   localparam logic [OPCODE_WIDTH-1:0] OP_APPEND = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ   = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE = 2'd2;

   localparam logic [ERROR_WIDTH-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_WIDTH-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERROR_WIDTH-1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [POS_WIDTH-1:0]    position;
      logic [VALUE_WIDTH-1:0]  value_in;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value_out;
      logic [ENTRY_WIDTH-1:0] entry_count;
      logic                   is_empty;
      logic [ERROR_WIDTH-1:0] error_code;
   } rsp_type;

endpackage

FILE: rtl/ilc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ilc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/indexed_list_with_compaction.sv
// ----------------------------------------------------------------------------
// Indexed list with compaction
// Bounded ordered list of words with append, indexed read and remove.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// rsp_data for one cycle with rsp_strobe and cannot be held off. An append,
// an out-of-range request or the unused opcode gives its result in the cycle
// after it is taken and never raises busy. A read goes through ST_READ; a
// remove goes through ST_HEAD, then ST_SHIFT while later entries remain, as the
// single read port of the entry RAM moves one later entry down per cycle.
module indexed_list_with_compaction
   import ilc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_HEAD  = 2'd2;
   localparam logic [1:0] ST_SHIFT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [ADDR_WIDTH-1:0]  rd_ff, rd_in;
   logic [ADDR_WIDTH-1:0]  wr_ff, wr_in;
   logic [DATA_WIDTH-1:0]  hold_ff, hold_in;
   logic                   strobe_ff, strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_wr_en;
   logic [ADDR_WIDTH-1:0]  ram_wr_addr;
   logic [DATA_WIDTH-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_WIDTH-1:0]  ram_rd_addr;
   logic [DATA_WIDTH-1:0]  ram_rd_data;

   logic [COUNT_WIDTH-1:0] next_rd;
   logic                   more;
   logic                   pos_ok;
   logic [COUNT_WIDTH-1:0] count_dec;

   ilc_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(LIST_CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign next_rd   = {1'b0, rd_ff} + COUNT_WIDTH'(1);
   assign more      = next_rd < count_ff;
   assign count_dec = count_ff - COUNT_WIDTH'(1);
   assign pos_ok    = COUNT_WIDTH'(req_data.position) < count_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      hold_in     = hold_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in          = 1'b1;
               rsp_in.value_out   = '0;
               rsp_in.error_code  = ERR_OK;
               rsp_in.entry_count = ENTRY_WIDTH'(count_ff);
               rsp_in.is_empty    = (count_ff == '0);
               case (req_data.opcode)
                  OP_APPEND: begin
                     if (count_ff == COUNT_WIDTH'(LIST_CAPACITY)) begin
                        rsp_in.error_code = ERR_FULL;
                     end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = count_ff[ADDR_WIDTH-1:0];
                        ram_wr_data        = DATA_WIDTH'(req_data.value_in);
                        count_in           = count_ff + COUNT_WIDTH'(1);
                        rsp_in.entry_count = ENTRY_WIDTH'(count_in);
                        rsp_in.is_empty    = 1'b0;
                     end
                  end
                  OP_READ, OP_REMOVE: begin
                     if (!pos_ok) begin
                        rsp_in.error_code = ERR_RANGE;
                     end else begin
                        strobe_in   = 1'b0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_WIDTH'(req_data.position);
                        rd_in       = ADDR_WIDTH'(req_data.position);
                        state_in    = (req_data.opcode == OP_READ) ? ST_READ : ST_HEAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            strobe_in          = 1'b1;
            rsp_in.value_out   = VALUE_WIDTH'(ram_rd_data);
            rsp_in.error_code  = ERR_OK;
            rsp_in.entry_count = ENTRY_WIDTH'(count_ff);
            rsp_in.is_empty    = 1'b0;
            state_in           = ST_IDLE;
         end
         ST_HEAD: begin
            hold_in = ram_rd_data;
            if (more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_rd[ADDR_WIDTH-1:0];
               rd_in       = next_rd[ADDR_WIDTH-1:0];
               wr_in       = rd_ff;
               state_in    = ST_SHIFT;
            end else begin
               count_in           = count_dec;
               strobe_in          = 1'b1;
               rsp_in.value_out   = VALUE_WIDTH'(ram_rd_data);
               rsp_in.error_code  = ERR_OK;
               rsp_in.entry_count = ENTRY_WIDTH'(count_dec);
               rsp_in.is_empty    = (count_dec == '0);
               state_in           = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_ff;
            ram_wr_data = ram_rd_data;
            if (more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_rd[ADDR_WIDTH-1:0];
               rd_in       = next_rd[ADDR_WIDTH-1:0];
               wr_in       = rd_ff;
            end else begin
               count_in           = count_dec;
               strobe_in          = 1'b1;
               rsp_in.value_out   = VALUE_WIDTH'(hold_ff);
               rsp_in.error_code  = ERR_OK;
               rsp_in.entry_count = ENTRY_WIDTH'(count_dec);
               rsp_in.is_empty    = (count_dec == '0);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(LIST_CAPACITY))
      else $error("Entry count exceeds the list capacity.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> ({1'b0, wr_ff} + COUNT_WIDTH'(1)) < count_ff)
      else $error("Shift writes outside the held entries.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while the sequencer is still working.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.entry_count == ENTRY_WIDTH'(count_ff))
      else $error("Reported entry count differs from the held count.");

endmodule

FILE: tb/ilc_tb_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list scoreboard
// Holds a shadow copy of the list, predicts one result per accepted item and
// checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
package ilc_tb_pkg;

   import ilc_pkg::*;

   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

   class ilc_list_scoreboard;

      logic [DATA_WIDTH-1:0] words [LIST_CAPACITY];
      int                    held;
      rsp_type               pending [$];
      int unsigned           failures;
      int unsigned           checked;
      int unsigned           op_count [4];
      int unsigned           range_errors;
      int unsigned           full_rejects;
      int                    peak;

      function new();
         held = 0;
         peak = 0;
         failures = 0;
         checked = 0;
         range_errors = 0;
         full_rejects = 0;
         foreach (op_count[i]) op_count[i] = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("ERROR: %s", msg);
      endfunction

      function string fields(rsp_type r);
         return $sformatf("value_out=%h entry_count=%0d is_empty=%b error_code=%0d",
                          r.value_out, r.entry_count, r.is_empty, r.error_code);
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         want = '0;
         op_count[item.opcode]++;
         case (item.opcode)
            OP_APPEND: begin
               if (held == LIST_CAPACITY) begin
                  want.error_code = ERR_FULL;
                  full_rejects++;
               end else begin
                  words[held] = item.value_in;
                  held++;
               end
            end
            OP_READ: begin
               if (int'(item.position) >= held) begin
                  want.error_code = ERR_RANGE;
                  range_errors++;
               end else begin
                  want.value_out = words[item.position];
               end
            end
            OP_REMOVE: begin
               if (int'(item.position) >= held) begin
                  want.error_code = ERR_RANGE;
                  range_errors++;
               end else begin
                  want.value_out = words[item.position];
                  for (int i = int'(item.position); i + 1 < held; i++) begin
                     words[i] = words[i + 1];
                  end
                  held--;
                  words[held] = '0;
               end
            end
            default: begin
            end
         endcase
         want.entry_count = ENTRY_WIDTH'(held);
         want.is_empty = (held == 0);
         if (held > peak) peak = held;
         pending.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            flag({"result with no item outstanding: ", fields(got)});
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.value_out !== want.value_out || got.entry_count !== want.entry_count ||
             got.is_empty !== want.is_empty || got.error_code !== want.error_code) begin
            flag({"result mismatch: expected ", fields(want), " got ", fields(got)});
         end
      endfunction

      function void close_out();
         if (pending.size() != 0) begin
            flag($sformatf("%0d expected results never arrived", pending.size()));
         end
      endfunction

   endclass

endpackage

FILE: tb/tb_indexed_list_with_compaction.sv
// ----------------------------------------------------------------------------
// Indexed list with compaction testbench
// Drives directed and random append, read, remove and unused-opcode items in bursts, and
// checks every result against a shadow list kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_indexed_list_with_compaction;

   timeunit 1ns;
   timeprecision 1ps;

   import ilc_pkg::*;
   import ilc_tb_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int DRAIN_CYCLES = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   ilc_list_scoreboard sb = new();
   int unsigned        burst_left;
   int unsigned        idle_cycles = 0;
   bit                 growing;

   indexed_list_with_compaction dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic req_type req_of(input logic [OPCODE_WIDTH-1:0] op,
                                      input logic [POS_WIDTH-1:0] pos,
                                      input logic [VALUE_WIDTH-1:0] val);
      req_type item;
      item.opcode = op;
      item.position = pos;
      item.value_in = val;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      roll;
      int      n;
      n = sb.held;
      roll = $urandom_range(0, 99);
      if (growing) begin
         item.opcode = roll < 55 ? OP_APPEND : roll < 75 ? OP_READ :
                       roll < 95 ? OP_REMOVE : OP_UNUSED;
      end else begin
         item.opcode = roll < 15 ? OP_APPEND : roll < 35 ? OP_READ :
                       roll < 95 ? OP_REMOVE : OP_UNUSED;
      end
      if (n > 0 && $urandom_range(0, 9) < 8) begin
         case ($urandom_range(0, 3))
            0: item.position = '0;
            1: item.position = POS_WIDTH'(n - 1);
            default: item.position = POS_WIDTH'($urandom_range(0, n - 1));
         endcase
      end else begin
         item.position = POS_WIDTH'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 9))
         0: item.value_in = '0;
         1: item.value_in = '1;
         default: item.value_in = $urandom;
      endcase
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(item);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            req_data <= random_item();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no item or result moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      burst_left = $urandom_range(1, 40);
      growing = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: every indexed access is out of range.
      send_item(req_of(OP_READ,   6'd0,  32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd0,  32'hFFFF_FFFF));
      send_item(req_of(OP_REMOVE, 6'd63, 32'h0000_0000));
      send_item(req_of(OP_UNUSED, 6'd0,  32'h1234_5678));
      send_item(req_of(OP_APPEND, 6'd63, 32'hFFFF_FFFF));
      send_item(req_of(OP_APPEND, 6'd0,  32'h0000_0000));
      send_item(req_of(OP_APPEND, 6'd17, 32'hA5A5_A5A5));
      send_item(req_of(OP_APPEND, 6'd42, 32'h5A5A_5A5A));
      send_item(req_of(OP_APPEND, 6'd1,  32'h0000_0001));
      send_item(req_of(OP_APPEND, 6'd2,  32'h8000_0000));
      send_item(req_of(OP_READ,   6'd0,  32'hFFFF_FFFF));
      send_item(req_of(OP_READ,   6'd5,  32'h0000_0000));
      send_item(req_of(OP_READ,   6'd6,  32'h0000_0000));
      send_item(req_of(OP_READ,   6'd63, 32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd2,  32'h0000_0000));
      send_item(req_of(OP_READ,   6'd2,  32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd4,  32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd0,  32'h0000_0000));
      send_item(req_of(OP_UNUSED, 6'd63, 32'hFFFF_FFFF));
      send_item(req_of(OP_REMOVE, 6'd63, 32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd0,  32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd0,  32'h0000_0000));
      send_item(req_of(OP_REMOVE, 6'd0,  32'h0000_0000));
      send_item(req_of(OP_READ,   6'd0,  32'h0000_0000));

      // Random items grow the list until it is full, then shrink it until it is empty, and repeat.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (sb.held == LIST_CAPACITY && $urandom_range(0, 3) == 0) begin
            growing = 1'b0;
         end else if (sb.held == 0) begin
            growing = 1'b1;
         end
         send_item(random_item());
      end

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();

      $display("Sent %0d appends, %0d reads, %0d removes and %0d unused opcodes.",
               sb.op_count[OP_APPEND], sb.op_count[OP_READ], sb.op_count[OP_REMOVE],
               sb.op_count[OP_UNUSED]);
      $display("Checked %0d results: %0d range errors, %0d full rejects, peak of %0d entries.",
               sb.checked, sb.range_errors, sb.full_rejects, sb.peak);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: indexed_list_with_compaction.f
rtl/ilc_pkg.sv
rtl/ilc_ram.sv
rtl/indexed_list_with_compaction.sv
tb/ilc_tb_pkg.sv
tb/tb_indexed_list_with_compaction.sv
